// ===== design/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;
   localparam int VOICES_DEF   = 16;
   localparam int CHANNELS     = 16;

   localparam logic [1:0] OP_MIDI     = 2'd0;
   localparam logic [1:0] OP_FINISHED = 2'd1;
   localparam logic [1:0] OP_KILL     = 2'd2;

   localparam logic [1:0] CMD_RELEASE = 2'd0;
   localparam logic [1:0] CMD_START   = 2'd1;
   localparam logic [1:0] CMD_AFTER   = 2'd2;

   localparam logic [1:0] ST_FREE     = 2'd0;
   localparam logic [1:0] ST_ACTIVE   = 2'd1;
   localparam logic [1:0] ST_RELEASED = 2'd2;

   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_POLY_AT  = 4'hA;
   localparam logic [3:0] TYPE_CTRL     = 4'hB;
   localparam logic [6:0] CTRL_SUSTAIN  = 7'd64;
   localparam logic [7:0] NO_KEY        = 8'd255;

   // one voice record as seen by the scan unit
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] channel;
      logic [6:0] key;
      logic [6:0] velocity;
      logic       held;
   } voice_type;

   // scan results
   typedef struct packed {
      logic active_hit;   // first active same key/channel
      logic free_hit;     // first free
      logic rel_same_hit; // first released same key/channel
      logic rel_hit;      // lowest released
      logic same_hit;     // first same key/channel
   } scan_flags_type;
endpackage

// ===== design/pva_scan.sv =====
// ----------------------------------------------------------------------------
// pva_scan
// Shared compare unit: looks at one voice a cycle and keeps the candidates.
// ----------------------------------------------------------------------------
module pva_scan import pva_pkg::*; #(
   parameter int VOICES = VOICES_DEF,
   parameter int VW     = $clog2(VOICES)
) (
   input  logic           clock,
   input  logic           start,
   input  logic           step,
   input  logic [VW-1:0]  idx,
   input  voice_type      vrec,
   input  logic [3:0]     channel,
   input  logic [6:0]     key,
   output scan_flags_type flags,
   output logic [VW-1:0]  active_v,
   output logic [VW-1:0]  free_v,
   output logic [VW-1:0]  rel_same_v,
   output logic [VW-1:0]  rel_v,
   output logic [VW-1:0]  same_v,
   output logic [VW-1:0]  low_v
);
   scan_flags_type flags_ff, flags_in;
   logic [VW-1:0] act_ff, fre_ff, rsm_ff, rel_ff, sam_ff, low_ff;
   logic [6:0]    relvel_ff, lowvel_ff;
   logic          same;

   assign same = (vrec.channel == channel) && (vrec.key == key);

   always_comb begin
      flags_in = start ? '0 : flags_ff;
      if (step && !start) begin
         if (vrec.status == ST_ACTIVE && same) flags_in.active_hit = 1'b1;
         if (vrec.status == ST_FREE) flags_in.free_hit = 1'b1;
         if (vrec.status == ST_RELEASED && same) flags_in.rel_same_hit = 1'b1;
         if (vrec.status == ST_RELEASED) flags_in.rel_hit = 1'b1;
         if (same) flags_in.same_hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      if (step && !start) begin
         if (!flags_ff.active_hit && vrec.status == ST_ACTIVE && same) act_ff <= idx;
         if (!flags_ff.free_hit && vrec.status == ST_FREE) fre_ff <= idx;
         if (!flags_ff.rel_same_hit && vrec.status == ST_RELEASED && same) rsm_ff <= idx;
         if (vrec.status == ST_RELEASED &&
             (!flags_ff.rel_hit || vrec.velocity < relvel_ff)) begin
            rel_ff    <= idx;
            relvel_ff <= vrec.velocity;
         end
         if (!flags_ff.same_hit && same) sam_ff <= idx;
         if (idx == '0 || vrec.velocity < lowvel_ff) begin
            low_ff    <= idx;
            lowvel_ff <= vrec.velocity;
         end
      end
   end

   assign flags      = flags_ff;
   assign active_v   = act_ff;
   assign free_v     = fre_ff;
   assign rel_same_v = rsm_ff;
   assign rel_v      = rel_ff;
   assign same_v     = sam_ff;
   assign low_v      = low_ff;
endmodule

// ===== design/polyphonic_voice_allocator_top.sv =====
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top
// MIDI voice allocator with sustain and voice stealing.
// ----------------------------------------------------------------------------
// A note-on makes two scans of the voice table, one voice per cycle through the
// shared compare unit, before it shows its start item; a pedal release walks
// the voices and emits a release for each held active voice on its channel.
// Output stalls hold the allocator. One item in flight at a time. Reset
// (synchronous) frees every voice, lifts every pedal and sets every channel's
// last key to 255.
module polyphonic_voice_allocator_top import pva_pkg::*; #(
   parameter int VOICES = VOICES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_status_byte,
   input  logic [6:0] req_data_one,
   input  logic [6:0] req_data_two,
   input  logic [3:0] req_finished_voice,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_command,
   output logic [3:0] rsp_voice,
   output logic [3:0] rsp_midi_channel,
   output logic [6:0] rsp_key,
   output logic [6:0] rsp_amount,
   output logic [7:0] rsp_previous_key,
   output logic       rsp_stolen,
   output logic       rsp_last
);
   localparam int VW = $clog2(VOICES);
   localparam logic [VW-1:0] VMAX = VW'(VOICES - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DEC    = 4'd1;
   localparam logic [3:0] S_SCAN1  = 4'd2;
   localparam logic [3:0] S_ACT1   = 4'd3;  // act on first scan
   localparam logic [3:0] S_SCAN2  = 4'd4;
   localparam logic [3:0] S_START  = 4'd5;
   localparam logic [3:0] S_PEDAL  = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;
   localparam logic [3:0] S_KILL   = 4'd8;

   // voice table in flops; read at the scan index and one chosen index
   logic [1:0] status_ff [VOICES];
   logic [3:0] vch_ff    [VOICES];
   logic [6:0] vkey_ff   [VOICES];
   logic [6:0] vvel_ff   [VOICES];
   logic       held_ff   [VOICES];
   logic       pedal_ff  [CHANNELS];
   logic [7:0] lastkey_ff[CHANNELS];

   logic [3:0]    state_ff;
   logic [VW-1:0] idx_ff;
   logic [1:0]    op_ff;
   logic [3:0]    type_ff, ch_ff, fv_ff;
   logic [6:0]    d1_ff, d2_ff;
   logic          note_on_ff; // second part of note-on pending
   logic          pend_ff;    // a captured pedal release waiting to be emitted

   logic          out_v_ff;
   logic [1:0]    o_cmd_ff;
   logic [3:0]    o_voice_ff, o_ch_ff;
   logic [6:0]    o_key_ff, o_amt_ff;
   logic [7:0]    o_prev_ff;
   logic          o_stolen_ff, o_last_ff;

   voice_type      vrec;
   scan_flags_type flags;
   logic [VW-1:0]  active_v, free_v, rel_same_v, rel_v, same_v, low_v, pick_v;
   logic           scan_start, scan_step;

   assign vrec = '{status: status_ff[idx_ff], channel: vch_ff[idx_ff],
                   key: vkey_ff[idx_ff], velocity: vvel_ff[idx_ff],
                   held: held_ff[idx_ff]};
   // clear the candidates on decode, and after the first scan only once it is acted on
   assign scan_start = (state_ff == S_DEC) ||
                       (state_ff == S_ACT1 && (!out_v_ff || !rsp_stall));
   assign scan_step  = (state_ff == S_SCAN1) || (state_ff == S_SCAN2);

   pva_scan #(.VOICES(VOICES), .VW(VW)) u_scan (
      .clock(clock), .start(scan_start), .step(scan_step),
      .idx(idx_ff), .vrec(vrec), .channel(ch_ff), .key(d1_ff),
      .flags(flags), .active_v(active_v), .free_v(free_v),
      .rel_same_v(rel_same_v), .rel_v(rel_v), .same_v(same_v), .low_v(low_v));

   // pick order: free first; steal order: released same, lowest released, same, lowest
   always_comb begin
      priority if (flags.free_hit)     pick_v = free_v;
      else if (flags.rel_same_hit)     pick_v = rel_same_v;
      else if (flags.rel_hit)          pick_v = rel_v;
      else if (flags.same_hit)         pick_v = same_v;
      else                             pick_v = low_v;
   end

   logic is_off;
   assign is_off = (type_ff == TYPE_NOTE_OFF) ||
                   (type_ff == TYPE_NOTE_ON && d2_ff == 7'd0);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            status_ff[i] <= ST_FREE;
            held_ff[i]   <= 1'b0;
            vch_ff[i]    <= '0;
            vkey_ff[i]   <= '0;
            vvel_ff[i]   <= '0;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            pedal_ff[c]   <= 1'b0;
            lastkey_ff[c] <= NO_KEY;
         end
      end else begin
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_operation;
                  type_ff <= req_status_byte[7:4];
                  ch_ff   <= req_status_byte[3:0];
                  d1_ff   <= req_data_one;
                  d2_ff   <= req_data_two;
                  fv_ff   <= req_finished_voice;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               idx_ff <= '0;
               note_on_ff <= 1'b0;
               pend_ff <= 1'b0;
               priority if (op_ff == OP_FINISHED) begin
                  if ({1'b0, fv_ff} < 5'(VOICES)) begin
                     status_ff[fv_ff[VW-1:0]] <= ST_FREE;
                     held_ff[fv_ff[VW-1:0]]   <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end else if (op_ff == OP_KILL) begin
                  state_ff <= S_KILL;
               end else if (op_ff == OP_MIDI &&
                            (type_ff == TYPE_NOTE_OFF || type_ff == TYPE_NOTE_ON ||
                             type_ff == TYPE_POLY_AT)) begin
                  note_on_ff <= !is_off && type_ff == TYPE_NOTE_ON;
                  state_ff <= S_SCAN1;
               end else if (op_ff == OP_MIDI && type_ff == TYPE_CTRL &&
                            d1_ff == CTRL_SUSTAIN) begin
                  pedal_ff[ch_ff] <= (d2_ff != 7'd0);
                  state_ff <= (d2_ff == 7'd0) ? S_PEDAL : S_IDLE;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_KILL: begin
               for (int i = 0; i < VOICES; i++) begin
                  status_ff[i] <= ST_FREE;
                  held_ff[i]   <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            S_SCAN1: begin
               idx_ff <= idx_ff + VW'(1);
               if (idx_ff == VMAX) state_ff <= S_ACT1;
            end
            S_ACT1: begin
               // wait for the output register before emitting
               if (!out_v_ff || !rsp_stall) begin
                  idx_ff <= '0;
                  state_ff <= note_on_ff ? S_SCAN2 : S_IDLE;
                  o_voice_ff <= 4'(active_v);
                  o_ch_ff    <= vch_ff[active_v];
                  o_key_ff   <= vkey_ff[active_v];
                  o_prev_ff  <= '0;
                  o_stolen_ff <= 1'b0;
                  o_last_ff  <= !note_on_ff;
                  o_cmd_ff   <= CMD_RELEASE;
                  o_amt_ff   <= '0;
                  if (flags.active_hit) begin
                     if (type_ff == TYPE_POLY_AT) begin
                        o_cmd_ff <= CMD_AFTER;
                        o_amt_ff <= d2_ff;
                        out_v_ff <= 1'b1;
                     end else if (note_on_ff || !pedal_ff[ch_ff]) begin
                        status_ff[active_v] <= ST_RELEASED;
                        out_v_ff <= 1'b1;
                     end else begin
                        held_ff[active_v] <= 1'b1;
                     end
                  end
               end
            end
            S_SCAN2: begin
               idx_ff <= idx_ff + VW'(1);
               if (idx_ff == VMAX) state_ff <= S_START;
            end
            S_START: begin
               if (!out_v_ff || !rsp_stall) begin
                  status_ff[pick_v] <= ST_ACTIVE;
                  vch_ff[pick_v]    <= ch_ff;
                  vkey_ff[pick_v]   <= d1_ff;
                  vvel_ff[pick_v]   <= d2_ff;
                  held_ff[pick_v]   <= 1'b0;
                  lastkey_ff[ch_ff] <= {1'b0, d1_ff};
                  o_cmd_ff    <= CMD_START;
                  o_voice_ff  <= 4'(pick_v);
                  o_ch_ff     <= ch_ff;
                  o_key_ff    <= d1_ff;
                  o_amt_ff    <= d2_ff;
                  o_prev_ff   <= lastkey_ff[ch_ff];
                  o_stolen_ff <= !flags.free_hit;
                  o_last_ff   <= 1'b1;
                  out_v_ff    <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            S_PEDAL: begin
               // walk voices; emit a release for each held active voice
               if (vch_ff[idx_ff] == ch_ff && held_ff[idx_ff] &&
                   status_ff[idx_ff] == ST_ACTIVE) begin
                  if (pend_ff) begin
                     if (!out_v_ff || !rsp_stall) begin
                        out_v_ff <= 1'b1;
                        o_last_ff <= 1'b0;
                        pend_ff <= 1'b0;
                     end
                  end else if (!out_v_ff || !rsp_stall) begin
                     // hold the capture until the output register is free
                     status_ff[idx_ff] <= ST_RELEASED;
                     held_ff[idx_ff]   <= 1'b0;
                     o_cmd_ff <= CMD_RELEASE;
                     o_voice_ff <= 4'(idx_ff);
                     o_ch_ff <= vch_ff[idx_ff];
                     o_key_ff <= vkey_ff[idx_ff];
                     o_amt_ff <= '0; o_prev_ff <= '0; o_stolen_ff <= 1'b0;
                     pend_ff <= 1'b1;
                     if (idx_ff == VMAX) state_ff <= S_OUT;
                     else idx_ff <= idx_ff + VW'(1);
                  end
               end else if (pend_ff && !(idx_ff == VMAX)) begin
                  idx_ff <= idx_ff + VW'(1);
               end else if (idx_ff == VMAX) begin
                  state_ff <= pend_ff ? S_OUT : S_IDLE;
               end else begin
                  idx_ff <= idx_ff + VW'(1);
               end
            end
            S_OUT: begin
               // flush the held item as the final one
               if (!out_v_ff || !rsp_stall) begin
                  out_v_ff <= 1'b1;
                  o_last_ff <= 1'b1;
                  pend_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_command      = o_cmd_ff;
   assign rsp_voice        = o_voice_ff;
   assign rsp_midi_channel = o_ch_ff;
   assign rsp_key          = o_key_ff;
   assign rsp_amount       = o_amt_ff;
   assign rsp_previous_key = o_prev_ff;
   assign rsp_stolen       = o_stolen_ff;
   assign rsp_last         = o_last_ff;
   logic unused;
   assign unused = vrec.held;
endmodule
